@@ sv/utf8d_pkg.sv @@
package utf8d_pkg;

    // Payload widths
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned LEN_W  = 3;
    localparam int unsigned PEND_DEPTH = 4;
    localparam int unsigned PEND_IDX_W = $clog2(PEND_DEPTH);

    // Request codes
    typedef enum logic
    {
        REQ_FEED  = 1'b0,
        REQ_CLEAR = 1'b1
    } req_t;

    // Result status codes
    typedef enum logic [1:0]
    {
        ST_PENDING = 2'd0,
        ST_READY   = 2'd1,
        ST_ILLEGAL = 2'd2
    } status_t;

    // Code point limits
    localparam logic [CP_W-1:0] CP_MIN_2     = 21'h00080;
    localparam logic [CP_W-1:0] CP_MIN_3     = 21'h00800;
    localparam logic [CP_W-1:0] CP_MIN_4     = 21'h10000;
    localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h0D800;
    localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h0DFFF;
    localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;

    // Sequence length announced by a lead byte, zero for a bad lead
    function automatic logic [LEN_W-1:0] lead_len(input logic [BYTE_W-1:0] b);
        logic [LEN_W-1:0] len;
        len = '0;
        priority if (b[7] == 1'b0)
            len = 3'd1;
        else if (b[7:5] == 3'b110)
            len = 3'd2;
        else if (b[7:4] == 4'b1110)
            len = 3'd3;
        else if (b[7:3] == 5'b11110)
            len = 3'd4;
        else
            len = 3'd0;
        return len;
    endfunction

endpackage

@@ sv/utf8d_if.sv @@
interface utf8d_in_if;
    logic                            valid;
    logic                            ready;
    logic                            req_type;
    logic [utf8d_pkg::BYTE_W-1:0]    byte_in;

    modport source (output valid, output req_type, output byte_in, input ready);
    modport sink   (input valid, input req_type, input byte_in, output ready);
endinterface

interface utf8d_out_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      status;
    logic [utf8d_pkg::CP_W-1:0]      code_point;

    modport source (output valid, output status, output code_point, input ready);
    modport sink   (input valid, input status, input code_point, output ready);
endinterface

@@ sv/utf8_byte_stream_decoder.sv @@
// Channel   Dir   Word fields               Handshake
// in_ch     in    req_type, byte_in         valid/ready
// out_ch    out   status, code_point        valid/ready
//
// Every input word gives exactly one result word; one word per cycle sustained while out_ch does not stall.
// A word passes through the input register, then decode logic into the result register.
// Decoder state (held count, announced length, buffered bytes) updates as a word
// moves from the input register to the result register.
// A stalled out_ch holds the result register and then the input register; rst_n clears
// both valid flags, the held count and the announced length.
module utf8_byte_stream_decoder
(
    input logic         clk,
    input logic         rst_n,
    utf8d_in_if.sink    in_ch,
    utf8d_out_if.source out_ch
);
    import utf8d_pkg::*;

    // Input register
    logic                  in_valid_reg;
    logic                  in_req_reg;
    logic [BYTE_W-1:0]     in_byte_reg;

    // Decoder state
    logic [LEN_W-1:0]      held_reg, held_next;
    logic [LEN_W-1:0]      needed_reg, needed_next;
    logic [BYTE_W-1:0]     pend_reg [PEND_DEPTH];
    logic                  pend_we;

    // Result register
    logic                  out_valid_reg;
    status_t               status_reg, status_next;
    logic [CP_W-1:0]       cp_reg, cp_next;

    logic                  advance;
    logic [LEN_W-1:0]      need;
    logic [LEN_W-1:0]      held_inc;
    logic [CP_W-1:0]       asm_cp;
    logic                  asm_ok;

    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.status     = status_reg;
    assign out_ch.code_point = cp_reg;

    // Length in effect: from the lead byte when nothing is held
    assign need     = (held_reg == '0) ? lead_len(in_byte_reg) : needed_reg;
    assign held_inc = LEN_W'(held_reg + 3'd1);

    // Assemble the sequence with the current byte as its last byte
    always_comb
    begin
        asm_cp = '0;
        asm_ok = 1'b0;
        unique case (need)
            3'd1:
            begin
                asm_cp = {13'd0, in_byte_reg};
                asm_ok = (in_byte_reg[7] == 1'b0);
            end
            3'd2:
            begin
                asm_cp = {10'd0, pend_reg[0][4:0], in_byte_reg[5:0]};
                asm_ok = (asm_cp >= CP_MIN_2);
            end
            3'd3:
            begin
                asm_cp = {5'd0, pend_reg[0][3:0], pend_reg[1][5:0], in_byte_reg[5:0]};
                asm_ok = (asm_cp >= CP_MIN_3)
                      && !((asm_cp >= CP_SURR_LO) && (asm_cp <= CP_SURR_HI));
            end
            3'd4:
            begin
                asm_cp = {pend_reg[0][2:0], pend_reg[1][5:0], pend_reg[2][5:0],
                          in_byte_reg[5:0]};
                asm_ok = (asm_cp >= CP_MIN_4) && (asm_cp <= CP_MAX);
            end
            default:
            begin
                asm_cp = '0;
                asm_ok = 1'b0;
            end
        endcase
    end

    // Decode one word against the held state
    always_comb
    begin
        held_next   = held_reg;
        needed_next = needed_reg;
        status_next = ST_PENDING;
        cp_next     = '0;
        pend_we     = 1'b0;
        priority if (in_req_reg == REQ_CLEAR)
        begin
            held_next   = '0;
            needed_next = '0;
        end
        else if (in_byte_reg == '0)
        begin
            status_next = (held_reg != '0) ? ST_ILLEGAL : ST_READY;
        end
        else if ((held_reg == '0) && (need == '0))
        begin
            status_next = ST_ILLEGAL;
        end
        else if ((held_reg != '0) && (in_byte_reg[7:6] != 2'b10))
        begin
            held_next   = '0;
            needed_next = '0;
            status_next = ST_ILLEGAL;
        end
        else if (held_inc < need)
        begin
            pend_we     = 1'b1;
            held_next   = held_inc;
            needed_next = need;
        end
        else
        begin
            held_next   = '0;
            needed_next = '0;
            if (asm_ok)
            begin
                status_next = ST_READY;
                cp_next     = asm_cp;
            end
            else
            begin
                status_next = ST_ILLEGAL;
            end
        end
    end

    // Load the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            in_req_reg  <= in_ch.req_type;
            in_byte_reg <= in_ch.byte_in;
        end
    end

    // Advance decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg   <= '0;
            needed_reg <= '0;
        end
        else if (advance)
        begin
            held_reg   <= held_next;
            needed_reg <= needed_next;
        end
    end

    // Buffer a byte of an open sequence
    always_ff @(posedge clk)
    begin
        if (advance && pend_we)
        begin
            pend_reg[held_reg[PEND_IDX_W-1:0]] <= in_byte_reg;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg <= status_next;
            cp_reg     <= cp_next;
        end
    end

    // Open sequence never holds as many bytes as it announced
    a_held_below_needed: assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg != '0) |-> (held_reg < needed_reg))
        else $error("held count not below announced length");

    // Clear request empties the decoder
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_req_reg == REQ_CLEAR)) |=> (held_reg == '0) && (needed_reg == '0))
        else $error("clear request left state behind");

    // Ready code point is a scalar value
    a_cp_scalar: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == ST_READY)) |->
            ((cp_reg <= CP_MAX) && !((cp_reg >= CP_SURR_LO) && (cp_reg <= CP_SURR_HI))))
        else $error("code point outside scalar range");

    // Code point is zero unless ready
    a_cp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != ST_READY)) |-> (cp_reg == '0))
        else $error("code point set on non-ready result");

    // Unsent result holds while stalled
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=> out_valid_reg && $stable(status_reg)
            && $stable(cp_reg))
        else $error("stalled result changed");

endmodule

@@ tb/tb_utf8_byte_stream_decoder.sv @@
`timescale 1ns / 100ps

module tb_utf8_byte_stream_decoder;
    import utf8d_pkg::*;

    localparam int unsigned RANDOM_WORDS     = 1600;
    localparam int unsigned CYCLE_LIMIT      = 200000;
    localparam int unsigned DRAIN_CYCLES     = 12;
    localparam int unsigned SHOWN_MISMATCHES = 10;

    typedef struct packed
    {
        status_t         status;
        logic [CP_W-1:0] code_point;
    } decoded_t;

    // Track decoder state and the results still owed by the block
    class decode_checker;
        logic [BYTE_W-1:0] seq_bytes [PEND_DEPTH];
        logic [LEN_W-1:0]  held;
        logic [LEN_W-1:0]  needed;
        decoded_t          awaited [$];
        int unsigned       mismatches;

        function new();
            held       = '0;
            needed     = '0;
            mismatches = 0;
        endfunction

        // Turn the buffered sequence into a scalar value or flag it illegal
        function decoded_t finish_sequence();
            decoded_t        r;
            logic [CP_W-1:0] v;
            bit              legal;
            v     = '0;
            legal = 1'b0;
            case (held)
                3'd1:
                begin
                    v     = {13'd0, seq_bytes[0]};
                    legal = !seq_bytes[0][7];
                end
                3'd2:
                begin
                    v     = {10'd0, seq_bytes[0][4:0], seq_bytes[1][5:0]};
                    legal = (v >= CP_MIN_2);
                end
                3'd3:
                begin
                    v     = {5'd0, seq_bytes[0][3:0], seq_bytes[1][5:0], seq_bytes[2][5:0]};
                    legal = (v >= CP_MIN_3) && !(v >= CP_SURR_LO && v <= CP_SURR_HI);
                end
                3'd4:
                begin
                    v     = {seq_bytes[0][2:0], seq_bytes[1][5:0], seq_bytes[2][5:0],
                             seq_bytes[3][5:0]};
                    legal = (v >= CP_MIN_4) && (v <= CP_MAX);
                end
                default:
                begin
                    legal = 1'b0;
                end
            endcase
            r.status     = legal ? ST_READY : ST_ILLEGAL;
            r.code_point = legal ? v : '0;
            return r;
        endfunction

        // Advance the decoder by one accepted input word
        function void take_word(req_t req, logic [BYTE_W-1:0] b);
            decoded_t r;
            bit       ok;
            r.status     = ST_PENDING;
            r.code_point = '0;
            if (req == REQ_CLEAR)
            begin
                held   = '0;
                needed = '0;
            end
            else if (b == 8'h00)
            begin
                // NUL keeps an open sequence untouched
                r.status = (held != 0) ? ST_ILLEGAL : ST_READY;
            end
            else
            begin
                ok = 1'b1;
                if (held == 0)
                begin
                    casez (b)
                        8'b0???????: needed = 3'd1;
                        8'b110?????: needed = 3'd2;
                        8'b1110????: needed = 3'd3;
                        8'b11110???: needed = 3'd4;
                        default:
                        begin
                            ok       = 1'b0;
                            r.status = ST_ILLEGAL;
                        end
                    endcase
                end
                else if (b[7:6] != 2'b10)
                begin
                    // drop the open sequence on a non-continuation byte
                    held     = '0;
                    needed   = '0;
                    ok       = 1'b0;
                    r.status = ST_ILLEGAL;
                end
                if (ok)
                begin
                    seq_bytes[held[1:0]] = b;
                    held = held + 3'd1;
                    if (held >= needed)
                    begin
                        r      = finish_sequence();
                        held   = '0;
                        needed = '0;
                    end
                end
            end
            awaited.push_back(r);
        endfunction

        // Compare one accepted result word with the oldest expectation
        function void match_result(logic [1:0] st, logic [CP_W-1:0] cp);
            decoded_t want;
            bit       bad;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_MISMATCHES)
                    $display("unexpected result word: status %0d code_point %h", st, cp);
                return;
            end
            want = awaited.pop_front();
            bad  = 1'b0;
            if (st !== want.status)
                bad = 1'b1;
            if (cp !== want.code_point)
                bad = 1'b1;
            if (bad)
            begin
                mismatches++;
                if (mismatches <= SHOWN_MISMATCHES)
                    $display("mismatch: expected status %0d cp %h, got status %0d cp %h",
                             want.status, want.code_point, st, cp);
            end
        endfunction

        function int unsigned outstanding();
            return awaited.size();
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    int unsigned   words_sent = 0;
    int unsigned   burst_left = 0;
    int unsigned   cycles     = 0;
    decode_checker tracker    = new();

    utf8d_in_if  in_ch();
    utf8d_out_if out_ch();

    utf8_byte_stream_decoder uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Sample both handshakes half a cycle ahead of the edge that completes them
    always @(negedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (in_ch.valid && in_ch.ready)
                tracker.take_word(req_t'(in_ch.req_type), in_ch.byte_in);
            if (out_ch.valid && out_ch.ready)
                tracker.match_result(out_ch.status, out_ch.code_point);
        end
    end

    // Stall the result channel in changing patterns
    initial
    begin
        int unsigned rx_mode;
        int unsigned rx_left;
        int unsigned rx_phase;
        out_ch.ready <= 1'b0;
        rx_mode  = 0;
        rx_left  = 0;
        rx_phase = 0;
        forever
        begin
            @(posedge clk);
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 300);
            end
            else
                rx_left--;
            rx_phase++;
            case (rx_mode)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       out_ch.ready <= ((rx_phase % 3) != 0);
                default: out_ch.ready <= ($urandom_range(0, 1) == 1);
            endcase
        end
    end

    // Offer one word, hold it until taken, then continue or end the burst
    task automatic send_word(input req_t req, input logic [BYTE_W-1:0] b);
        int unsigned gap_len;
        in_ch.valid    <= 1'b1;
        in_ch.req_type <= req;
        in_ch.byte_in  <= b;
        do
            @(negedge clk);
        while (!in_ch.ready);
        @(posedge clk);
        words_sent++;
        if (burst_left == 0)
        begin
            in_ch.valid <= 1'b0;
            gap_len = $urandom_range(1, 6);
            repeat (gap_len) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                      : $urandom_range(0, 12);
        end
        else
            burst_left--;
    endtask

    task automatic feed(input logic [BYTE_W-1:0] b);
        send_word(REQ_FEED, b);
    endtask

    // Hold off the sender until every owed result has arrived
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    function automatic logic [BYTE_W-1:0] lead_byte(input int unsigned len);
        logic [BYTE_W-1:0] b;
        case (len)
            1:       b = 8'($urandom_range(1, 127));
            2:       b = {3'b110, 5'($urandom)};
            3:       b = {4'b1110, 4'($urandom)};
            default: b = {5'b11110, 3'($urandom)};
        endcase
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] cont_byte();
        return {2'b10, 6'($urandom)};
    endfunction

    function automatic logic [BYTE_W-1:0] non_cont_byte();
        logic [BYTE_W-1:0] b;
        if ($urandom_range(0, 1) == 1)
            b = {1'b0, 7'($urandom)};
        else
            b = {2'b11, 6'($urandom)};
        return b;
    endfunction

    // Feed mostly well-formed sequences, mixed with broken ones and noise
    task automatic send_random_stream(input int unsigned stop_at);
        int unsigned pick;
        int unsigned len;
        int unsigned cut;
        int unsigned k;
        int unsigned mid_point;
        bit          drained_mid;
        mid_point   = words_sent + (stop_at - words_sent) / 2;
        drained_mid = 1'b0;
        while (words_sent < stop_at)
        begin
            if (!drained_mid && words_sent >= mid_point)
            begin
                wait_drained();
                drained_mid = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                len = $urandom_range(1, 4);
                feed(lead_byte(len));
                for (k = 1; k < len; k++)
                    feed(cont_byte());
            end
            else if (pick < 75)
            begin
                // cut a sequence short with a foreign byte
                len = $urandom_range(2, 4);
                cut = $urandom_range(1, len - 1);
                feed(lead_byte(len));
                for (k = 1; k < cut; k++)
                    feed(cont_byte());
                feed(non_cont_byte());
            end
            else if (pick < 83)
            begin
                // NUL inside an open sequence, then complete it
                len = $urandom_range(2, 4);
                feed(lead_byte(len));
                feed(8'h00);
                for (k = 1; k < len; k++)
                    feed(cont_byte());
            end
            else if (pick < 89)
            begin
                if ($urandom_range(0, 1) == 1)
                    feed(lead_byte($urandom_range(2, 4)));
                send_word(REQ_CLEAR, 8'($urandom));
            end
            else
                feed(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        in_ch.valid    <= 1'b0;
        in_ch.req_type <= REQ_FEED;
        in_ch.byte_in  <= '0;
        rst_n          <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // clear, NUL with nothing open, ASCII top, bad leads
        send_word(REQ_CLEAR, 8'hFF);
        feed(8'h00);
        feed(8'h7F);
        feed(8'h80);
        feed(8'hF8);
        // overlong two-byte form
        feed(8'hC0);
        feed(8'h80);
        // surrogate
        feed(8'hED);
        feed(8'hA0);
        feed(8'h80);
        // NUL inside a sequence keeps it open
        feed(8'hE2);
        feed(8'h00);
        feed(8'h82);
        feed(8'hAC);
        // non-continuation byte inside a sequence
        feed(8'hE2);
        feed(8'h41);
        // clear with a sequence open
        feed(8'hF4);
        send_word(REQ_CLEAR, 8'h00);
        // largest scalar value, then one above it
        feed(8'hF4);
        feed(8'h8F);
        feed(8'hBF);
        feed(8'hBF);
        feed(8'hF4);
        feed(8'h90);
        feed(8'h80);
        feed(8'h80);
        wait_drained();

        send_random_stream(words_sent + RANDOM_WORDS);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
